// ===== sv/assert_macros.svh =====
// assertion macros shared by the circular deque rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CDQ_ASSERT(label, clk, rst_n, prop, msg)
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/cdq_pkg.sv =====
// types and constants for the circular deque unit
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package cdq_pkg;

	localparam int VALUE_W = 32;
	localparam int LEVEL_W = 5;

	// operation codes of a request transaction
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] push_value;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] pop_value;
		status_t            status;
		logic [LEVEL_W-1:0] fill_level;
		logic               is_empty;
		logic               is_full;
	} rsp_item_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} cdq_cmd_t;

endpackage

`default_nettype wire

// ===== sv/cdq_ctrl.sv =====
// controller of the circular deque: sequences capture, execute and result load
// depends on cdq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output cdq_pkg::cdq_cmd_t      cmd
);
	import cdq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				// result register free or being emptied this cycle
				if (!valid_q || !rsp_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = valid_q;

	`CDQ_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0({cmd.capture, cmd.exec, cmd.load_out}), "more than one command active")
	`CDQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, req_valid && !req_stall, cmd.exec, "accepted transaction not executed")
	`CDQ_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, rsp_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== sv/cdq_datapath.sv =====
// datapath of the circular deque: ring memory, head/tail pointers, count, result register
// depends on cdq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cdq_datapath #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cdq_pkg::cdq_cmd_t cmd,
	input  wire cdq_pkg::req_item_t req,
	output cdq_pkg::rsp_item_t     rsp
);
	import cdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_item_t        req_q;
	logic [WIDTH-1:0] ring_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	status_t          status_q;
	logic             pop_ok_q;
	rsp_item_t        rsp_q;

	logic [AW-1:0]    head_d;
	logic [AW-1:0]    tail_d;
	logic [CW-1:0]    count_d;
	logic [AW-1:0]    head_inc;
	logic [AW-1:0]    head_dec;
	logic [AW-1:0]    tail_inc;
	logic [AW-1:0]    tail_dec;
	logic             is_full;
	logic             is_empty;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	status_t          status_d;
	logic             pop_ok_d;
	logic [CW:0]      ht_sum;
	logic [AW-1:0]    ht_wrap;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// pointer steps with wrap at the ring end
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign tail_inc = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? AW'(DEPTH - 1) : tail_q - 1'b1;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// operation decode
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		wr_en    = 1'b0;
		wr_addr  = head_dec;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		status_d = STATUS_OK;
		pop_ok_d = 1'b0;
		case (req_q.kind)
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					head_d  = head_dec;
					wr_en   = 1'b1;
					wr_addr = head_dec;
					count_d = count_q + 1'b1;
				end
			end
			KIND_PUSH_REAR: begin
				if (is_full) begin
					status_d = STATUS_FULL;
				end else begin
					tail_d  = tail_inc;
					wr_en   = 1'b1;
					wr_addr = tail_inc;
					count_d = count_q + 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = head_q;
					head_d   = head_inc;
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
				end
			end
			KIND_POP_REAR: begin
				if (is_empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = tail_q;
					tail_d   = tail_dec;
					count_d  = count_q - 1'b1;
					pop_ok_d = 1'b1;
				end
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= AW'(DEPTH - 1);
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// per-transaction outcome
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	// ring memory, one write or one registered read per transaction
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			ring_q[wr_addr] <= WIDTH'(req_q.push_value);
		end
		if (cmd.exec && rd_en) begin
			rd_data_q <= ring_q[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.pop_value  <= pop_ok_q ? VALUE_W'(rd_data_q) : '0;
			rsp_q.status     <= status_q;
			rsp_q.fill_level <= LEVEL_W'(count_q);
			rsp_q.is_empty   <= is_empty;
			rsp_q.is_full    <= is_full;
		end
	end

	assign rsp = rsp_q;

	// tail should sit at head plus count minus one around the ring
	assign ht_sum  = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign ht_wrap = (ht_sum >= (CW + 1)'(DEPTH)) ? AW'(ht_sum - (CW + 1)'(DEPTH))
		: AW'(ht_sum);

	`CDQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "entry count above depth")
	`CDQ_ASSERT(a_ptr_consistent, clk, arst_n, ht_wrap == tail_inc, "head, tail and count disagree")
	`CDQ_ASSERT_NEXT(a_empty_result, clk, arst_n, cmd.load_out && (status_q == STATUS_EMPTY), rsp_q.is_empty && (rsp_q.pop_value == '0), "empty pop result malformed")

endmodule

`default_nettype wire

// ===== sv/circular_deque_unit.sv =====
// circular deque unit: push or pop at either end of a ring of DEPTH entries
// a request is captured, executed, then its result loaded; the load waits while an earlier result is stalled
// a new request is taken only after the result load of the last one, set by the controller sequence around
//   the single-port ring memory and its registered read
// a new request is taken while an earlier result still waits at the output
// reset sets head and count to zero and tail to DEPTH-1; ring contents are not reset
`default_nettype none

module circular_deque_unit #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire cdq_pkg::req_item_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output cdq_pkg::rsp_item_t      rsp
);
	import cdq_pkg::*;

	cdq_cmd_t cmd;

	// sequencing
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// storage and pointer arithmetic
	cdq_datapath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== sim/circular_deque_unit_test.sv =====
// self-checking testbench for circular_deque_unit: directed table, then random push/pop traffic
// depends on cdq_pkg and the circular_deque_unit rtl; results are checked against a local deque
`timescale 1ns / 100ps

module circular_deque_unit_test;

	import cdq_pkg::*;

	localparam int DEQUE_DEPTH = 16;
	localparam int RANDOM_ITEMS = 950;
	localparam int BLOCK_ITEMS = 50;
	localparam int LONG_HOLD = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		req_item_t req;
		bit        spelled_out;
		rsp_item_t rsp;
	} table_row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	// local copy of the deque contents and pointers
	logic [VALUE_W-1:0] ring_copy [DEQUE_DEPTH];
	logic [3:0]         front_idx;
	logic [3:0]         rear_idx;
	logic [LEVEL_W-1:0] occupancy;

	rsp_item_t  pending_rsp[$];
	table_row_t directed_rows[$];
	int         error_count;
	int         cycle_count;
	bit         calm;
	bit         hold_request;

	circular_deque_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// apply one transaction to the local deque and return the result it yields
	function automatic rsp_item_t deque_apply(input req_item_t item);
		rsp_item_t r;
		r = '0;
		r.status = STATUS_OK;
		case (item.kind)
			KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
				if (occupancy == DEQUE_DEPTH) begin
					r.status = STATUS_FULL;
				end else if (item.kind == KIND_PUSH_FRONT) begin
					front_idx = front_idx - 4'd1;
					ring_copy[front_idx] = item.push_value;
					occupancy = occupancy + 1'b1;
				end else begin
					rear_idx = rear_idx + 4'd1;
					ring_copy[rear_idx] = item.push_value;
					occupancy = occupancy + 1'b1;
				end
			end
			default: begin
				if (occupancy == 0) begin
					r.status = STATUS_EMPTY;
				end else if (item.kind == KIND_POP_FRONT) begin
					r.pop_value = ring_copy[front_idx];
					front_idx = front_idx + 4'd1;
					occupancy = occupancy - 1'b1;
				end else begin
					r.pop_value = ring_copy[rear_idx];
					rear_idx = rear_idx - 4'd1;
					occupancy = occupancy - 1'b1;
				end
			end
		endcase
		r.fill_level = occupancy;
		r.is_empty = (occupancy == 0);
		r.is_full = (occupancy == DEQUE_DEPTH);
		return r;
	endfunction

	function automatic rsp_item_t literal_rsp(input logic [VALUE_W-1:0] value,
			input status_t st, input logic [LEVEL_W-1:0] level, input logic emp,
			input logic ful);
		rsp_item_t r;
		r.pop_value = value;
		r.status = st;
		r.fill_level = level;
		r.is_empty = emp;
		r.is_full = ful;
		return r;
	endfunction

	task automatic add_row(input kind_t k, input logic [VALUE_W-1:0] value,
			input bit spelled_out, input rsp_item_t r);
		table_row_t row;
		row.req.kind = k;
		row.req.push_value = value;
		row.spelled_out = spelled_out;
		row.rsp = r;
		directed_rows.push_back(row);
	endtask

	// offer one request transaction after an optional gap, return at the falling edge after accept
	task automatic offer_req(input req_item_t item, input rsp_item_t typed_rsp,
			input bit use_typed);
		int gap;
		rsp_item_t predicted;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = deque_apply(item);
		pending_rsp.push_back(use_typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	// request side: reset, directed table, then random blocks
	initial begin : request_side
		req_item_t item;
		int push_pct;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		error_count = 0;
		calm = 1'b0;
		hold_request = 1'b0;
		front_idx = 4'd0;
		rear_idx = 4'(DEQUE_DEPTH - 1);
		occupancy = '0;

		// pops on empty, first push at the front then popped at the rear, extreme values
		add_row(KIND_POP_FRONT, 32'h0, 1, literal_rsp(32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0));
		add_row(KIND_POP_REAR, 32'hFFFF_FFFF, 1,
			literal_rsp(32'h0, STATUS_EMPTY, 5'd0, 1'b1, 1'b0));
		add_row(KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1,
			literal_rsp(32'h0, STATUS_OK, 5'd1, 1'b0, 1'b0));
		add_row(KIND_POP_REAR, 32'h0, 1,
			literal_rsp(32'hFFFF_FFFF, STATUS_OK, 5'd0, 1'b1, 1'b0));
		add_row(KIND_PUSH_REAR, 32'h0, 1, literal_rsp(32'h0, STATUS_OK, 5'd1, 1'b0, 1'b0));
		add_row(KIND_POP_FRONT, 32'hFFFF_FFFF, 1,
			literal_rsp(32'h0, STATUS_OK, 5'd0, 1'b1, 1'b0));
		// fill to the top from both ends
		for (int i = 0; i < DEQUE_DEPTH; i++) begin
			add_row((i % 2) ? KIND_PUSH_REAR : KIND_PUSH_FRONT,
				(i % 2) ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i + 1)), 0, '0);
		end
		// pushes on full are rejected at either end
		add_row(KIND_PUSH_FRONT, 32'h1234_5678, 1,
			literal_rsp(32'h0, STATUS_FULL, 5'd16, 1'b0, 1'b1));
		add_row(KIND_PUSH_REAR, 32'h8765_4321, 1,
			literal_rsp(32'h0, STATUS_FULL, 5'd16, 1'b0, 1'b1));
		add_row(KIND_POP_REAR, 32'h0, 0, '0);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_req(directed_rows[i].req, directed_rows[i].rsp, directed_rows[i].spelled_out);

		// random blocks with a push bias that drifts between filling and draining
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 80;
					1: push_pct = 50;
					default: push_pct = 20;
				endcase
				calm = ($urandom_range(0, 3) == 0);
				// long receiver hold-off while requests keep coming back to back
				if (n == 2 * BLOCK_ITEMS) begin
					calm = 1'b1;
					hold_request = 1'b1;
				end
			end
			if ($urandom_range(1, 100) <= push_pct)
				item.kind = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
			else
				item.kind = $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
			case ($urandom_range(0, 15))
				0: item.push_value = 32'h0;
				1: item.push_value = 32'hFFFF_FFFF;
				default: item.push_value = $urandom;
			endcase
			offer_req(item, '0, 0);
		end
		req_valid <= 1'b0;

		// drain and let the pipeline settle
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("[circular_deque_unit] OK");
		else
			$display("[circular_deque_unit] ERROR");
		$finish;
	end

	// response side: random stall before each transaction, one long hold-off on request
	initial begin : response_side
		int hold;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 12);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// compare each accepted result transaction with the oldest expectation
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with nothing expected, actual %0h", $time, rsp);
				error_count++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("pop_value", want.pop_value, rsp.pop_value);
				check_field("status", want.status, rsp.status);
				check_field("fill_level", want.fill_level, rsp.fill_level);
				check_field("is_empty", want.is_empty, rsp.is_empty);
				check_field("is_full", want.is_full, rsp.is_full);
			end
		end
	end

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[circular_deque_unit] ERROR");
			$finish;
		end
	end

endmodule
